### hdl/mceo_pkg.sv
// ----------------------------------------------------------------------------
// mceo_pkg - shared constants and helpers for mecanum encoder odometry
// Field widths, fixed-point layout and saturation helper.
// ----------------------------------------------------------------------------
package mceo_pkg;

    // encoder counter width; raw count fields are 16 bits wide
    localparam int CNT_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int WHEELS   = 4;
    localparam int SCALE_W  = 32;
    localparam int INV_W    = 24;
    localparam int SPEED_W  = 32;
    // four saturated speeds summed with signs
    localparam int SUM_W    = SPEED_W + 3;
    // |sum| * inv_half_span < 2^57, wheel products are far narrower
    localparam int ACC_W    = SUM_W + INV_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = WHEELS * COUNT_W;
    localparam int OUT_DATA_W = 7 * SPEED_W;

    // rounding points: Q.24 -> Q.16, quarter sum, Q.34 -> Q.16
    localparam int WHEEL_SHIFT = 8;
    localparam int QUART_SHIFT = 2;
    localparam int YAW_SHIFT   = 18;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(304262);
    localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(319688);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPAN = 3'd4;

    // clamp a wide signed value to the 32 bit signed range
    function automatic logic [SPEED_W-1:0] sat32(input logic [ACC_W-1:0] x);
        logic [SPEED_W-1:0] r;
        if (!x[ACC_W-1] && (|x[ACC_W-2:SPEED_W-1]))
            r = {1'b0, {(SPEED_W-1){1'b1}}};
        else if (x[ACC_W-1] && !(&x[ACC_W-2:SPEED_W-1]))
            r = {1'b1, {(SPEED_W-1){1'b0}}};
        else
            r = x[SPEED_W-1:0];
        return r;
    endfunction

endpackage

### hdl/mecanum_encoder_odometry.sv
// ----------------------------------------------------------------------------
// mecanum_encoder_odometry - wheel speeds and body velocity from encoders
// Wrap-around count deltas, per-wheel scaling and forward mecanum kinematics
// on one shared bit-serial shift-and-add multiplier.
// ----------------------------------------------------------------------------
// Each input word carries four raw encoder counts; the block returns one word
// with the four Q16.16 wheel speeds and vx, vy, wz. A new word is taken only
// in the idle state, after the last result has moved to the output register.
// All products run on the single bit-serial multiplier: 16 steps per wheel,
// each with a load and a rounding state, and 24 steps for the yaw-rate
// product. The result sits in an output register, so a stalled master side
// holds only the final hand-over, not the computation of the next word.
module mecanum_encoder_odometry
(
    input  logic                               clk,
    input  logic                               rst_n,
    // count_lf, count_rf, count_lr, count_rr (16 bits each, lowest first)
    input  logic [mceo_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // speed_lf, speed_rf, speed_lr, speed_rr, body_vx, body_vy, body_wz
    output logic [mceo_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [mceo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mceo_pkg::SCALE_W-1:0]       cfg_wdata
);
    import mceo_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WRND = 3'd3;
    localparam logic [2:0] S_SUMS = 3'd4;
    localparam logic [2:0] S_ZRND = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int CNTR_W = $clog2(INV_W);
    localparam int WHL_W  = $clog2(WHEELS);

    logic [2:0]              state_reg, state_next;
    logic [WHL_W-1:0]        wheel_reg, wheel_next;
    logic [CNTR_W-1:0]       cnt_reg, cnt_next;
    logic                    zphase_reg, zphase_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]        mcand_reg, mcand_next;
    logic [INV_W-1:0]        mplier_reg, mplier_next;
    logic [CNT_W-1:0]        prev_reg  [WHEELS];
    logic [CNT_W-1:0]        prev_next [WHEELS];
    logic [CNT_W-1:0]        delta_reg [WHEELS];
    logic [CNT_W-1:0]        delta_next[WHEELS];
    logic [SPEED_W-1:0]      speed_reg [WHEELS];
    logic [SPEED_W-1:0]      speed_next[WHEELS];
    logic [SPEED_W-1:0]      vx_reg, vx_next;
    logic [SPEED_W-1:0]      vy_reg, vy_next;
    logic [SPEED_W-1:0]      wz_reg, wz_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SCALE_W-1:0]      scale_reg [WHEELS];
    logic [INV_W-1:0]        inv_reg;

    logic                    mul_last;
    logic [ACC_W-1:0]        addend;
    logic [ACC_W-1:0]        rnd;
    logic signed [SUM_W-1:0] sp [WHEELS];
    logic signed [SUM_W-1:0] sx, sy, sw;
    logic signed [ACC_W-1:0] sx_ext, sy_ext;
    logic signed [ACC_W-1:0] rnd_s;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // last multiplier bit; for wheels it is the delta's sign bit
    assign mul_last = zphase_reg ? (cnt_reg == CNTR_W'(INV_W - 1))
                                 : (cnt_reg == CNTR_W'(CNT_W - 1));
    assign addend   = (mul_last && !zphase_reg) ? (~mcand_reg + 1'b1) : mcand_reg;

    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            sp[i] = {{(SUM_W-SPEED_W){speed_reg[i][SPEED_W-1]}}, speed_reg[i]};
        end
        sx = sp[0] + sp[1] + sp[2] + sp[3];
        sy = sp[1] + sp[2] - sp[0] - sp[3];
        sw = sp[1] + sp[3] - sp[0] - sp[2];
        sx_ext = {{(ACC_W-SUM_W){sx[SUM_W-1]}}, sx};
        sy_ext = {{(ACC_W-SUM_W){sy[SUM_W-1]}}, sy};
    end

    always_comb
    begin
        state_next     = state_reg;
        wheel_next     = wheel_reg;
        cnt_next       = cnt_reg;
        zphase_next    = zphase_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        prev_next      = prev_reg;
        delta_next     = delta_reg;
        speed_next     = speed_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        wz_next        = wz_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        rnd            = '0;
        rnd_s          = '0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < WHEELS; i++)
                    begin
                        prev_next[i]  = s_tdata[i*COUNT_W +: CNT_W];
                        delta_next[i] = s_tdata[i*COUNT_W +: CNT_W] - prev_reg[i];
                    end
                    wheel_next  = '0;
                    zphase_next = 1'b0;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                mcand_next  = {{(ACC_W-SCALE_W){scale_reg[wheel_reg][SCALE_W-1]}},
                               scale_reg[wheel_reg]};
                mplier_next = INV_W'(delta_reg[wheel_reg]);
                acc_next    = '0;
                cnt_next    = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + addend;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[INV_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (mul_last)
                    state_next = zphase_reg ? S_ZRND : S_WRND;
            end
            S_WRND:
            begin
                // round to nearest, ties up: add half, arithmetic shift
                rnd   = acc_reg + ACC_W'(1 << (WHEEL_SHIFT - 1));
                rnd_s = $signed(rnd) >>> WHEEL_SHIFT;
                speed_next[wheel_reg] = sat32(rnd_s);
                if (wheel_reg == WHL_W'(WHEELS - 1))
                begin
                    state_next = S_SUMS;
                end
                else
                begin
                    wheel_next = wheel_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_SUMS:
            begin
                vx_next     = sat32((sx_ext + ACC_W'(1 << (QUART_SHIFT - 1))) >>> QUART_SHIFT);
                vy_next     = sat32((sy_ext + ACC_W'(1 << (QUART_SHIFT - 1))) >>> QUART_SHIFT);
                mcand_next  = {{(ACC_W-SUM_W){sw[SUM_W-1]}}, sw};
                mplier_next = inv_reg;
                acc_next    = '0;
                cnt_next    = '0;
                zphase_next = 1'b1;
                state_next  = S_MUL;
            end
            S_ZRND:
            begin
                rnd        = acc_reg + ACC_W'(1 << (YAW_SHIFT - 1));
                rnd_s      = $signed(rnd) >>> YAW_SHIFT;
                wz_next    = sat32(rnd_s);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {wz_reg, vy_reg, vx_reg, speed_reg[3],
                                      speed_reg[2], speed_reg[1], speed_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wheel_reg     <= '0;
            cnt_reg       <= '0;
            zphase_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            inv_reg       <= INV_RESET;
            for (int i = 0; i < WHEELS; i++)
            begin
                prev_reg[i]  <= '0;
                scale_reg[i] <= SCALE_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            cnt_reg       <= cnt_next;
            zphase_reg    <= zphase_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCALE_LF: scale_reg[0] <= cfg_wdata;
                    REG_SCALE_RF: scale_reg[1] <= cfg_wdata;
                    REG_SCALE_LR: scale_reg[2] <= cfg_wdata;
                    REG_SCALE_RR: scale_reg[3] <= cfg_wdata;
                    REG_INV_SPAN: inv_reg      <= cfg_wdata[INV_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        delta_reg    <= delta_next;
        speed_reg    <= speed_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        wz_reg       <= wz_next;
        out_data_reg <= out_data_next;
    end

endmodule

### bench/tb_mecanum_encoder_odometry.sv
// ----------------------------------------------------------------------------
// tb_mecanum_encoder_odometry - self-checking bench for encoder odometry
// Drives raw encoder count words, predicts wheel speeds and body velocity
// in fixed point, and checks every result word field by field. A directed
// table comes first, followed by random phases that may each get new scales.
// ----------------------------------------------------------------------------
module tb_mecanum_encoder_odometry;

    import mceo_pkg::*;

    localparam int ODO_FIELDS    = 7;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 100;
    localparam int CALM_PHASE    = 3;
    localparam int PLAN_ROWS     = 46;

    localparam longint TOP32 = 64'sd2147483647;
    localparam longint BOT32 = -64'sd2147483648;

    // indexes past the last register, decoded by nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_INV_SPAN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

    // count_lf in the lowest bits
    typedef logic [WHEELS-1:0][COUNT_W-1:0] wheel_counts_t;
    // speed_lf, speed_rf, speed_lr, speed_rr, vx, vy, wz from index 0 up
    typedef logic [ODO_FIELDS-1:0][SPEED_W-1:0] odo_word_t;

    typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SCALE_W-1:0]     wdata;
        wheel_counts_t          counts;
        logic                   typed;
        odo_word_t              result;
    } plan_row_t;

    localparam odo_word_t ODO_IDLE    = '0;
    localparam odo_word_t ODO_ALL_MAX = {32'd0, 32'd0, {5{32'h7FFF_FFFF}}};
    localparam odo_word_t ODO_ALL_MIN = {32'd0, 32'd0, {5{32'h8000_0000}}};

    // counts written as rr_lr_rf_lf
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_WORD, '0, '0, 64'h0000_0000_0000_0000, 1'b1, ODO_IDLE},
        '{ROW_WORD, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0000_0000_0000_0000, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h8000_8000_8000_8000, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0010_FFF0_0020_FFE0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'hA5A5_5A5A_C3C3_3C3C, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h5A5A_A5A5_3C3C_C3C3, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0000_0000_0000_0000, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LF, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RF, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LR, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RR, 32'h7FFF_FFFF, '0, 1'b0, '0},
        // upper byte lies above the 24 bit register: reciprocal becomes zero
        '{ROW_CFG, REG_INV_SPAN, 32'hFF00_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_SPARE,    32'h0000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_TOP,      32'h0000_0000, '0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, ODO_ALL_MAX},
        '{ROW_WORD, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ODO_ALL_MIN},
        '{ROW_WORD, '0, '0, 64'h7FFF_8000_7FFF_8000, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0000_0000_0000_0000, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LF, 32'h8000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RF, 32'h7FFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LR, 32'h8000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_INV_SPAN, 32'h00FF_FFFF, '0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0001_0001_0001_0001, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h8001_8001_8001_8001, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0002_0000_FFFF_0001, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LF, 32'h0000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RF, 32'h0000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LR, 32'h0000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RR, 32'h0000_0000, '0, 1'b0, '0},
        '{ROW_CFG, REG_INV_SPAN, 32'h0000_0001, '0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h1234_5678_9ABC_DEF0, 1'b1, ODO_IDLE},
        '{ROW_CFG, REG_SCALE_LF, 32'h0000_0001, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RF, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LR, 32'h0000_0100, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RR, 32'hFFFF_FF00, '0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h1235_5677_9ABD_DEEF, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0000_0000_0000_0000, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LF, SCALE_RESET, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RF, SCALE_RESET, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_LR, SCALE_RESET, '0, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_RR, SCALE_RESET, '0, 1'b0, '0},
        '{ROW_CFG, REG_INV_SPAN, {8'h00, INV_RESET}, '0, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'h0003_FFFD_0002_FFFE, 1'b0, '0},
        '{ROW_WORD, '0, '0, 64'hFFF0_0010_FFF8_0008, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [SCALE_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [COUNT_W-1:0]     prev_count  [WHEELS];
    logic [SCALE_W-1:0]     wheel_scale [WHEELS];
    logic [INV_W-1:0]       yaw_recip;

    odo_word_t  pending_odometry [$];
    int         mismatch_count = 0;
    int         cycles_run     = 0;
    bit         calm           = 1'b0;
    string      field_name [ODO_FIELDS] =
        '{"speed_lf", "speed_rf", "speed_lr", "speed_rr", "body_vx", "body_vy", "body_wz"};
    int         reach_table [5] = '{3, 40, 600, 9000, 30000};

    mecanum_encoder_odometry uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // round to nearest, ties up: add half, floor
    function automatic longint round_half_up(input longint x, input int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > TOP32)
            return TOP32;
        if (x < BOT32)
            return BOT32;
        return x;
    endfunction

    function automatic odo_word_t advance_odometry(input wheel_counts_t c);
        odo_word_t              r;
        longint                 spd [WHEELS];
        longint                 delta, sx, sy, sw, recip;
        logic signed [CNT_W-1:0] wrapped;
        for (int w = 0; w < WHEELS; w++)
        begin
            // only the counter's own bits take part in the difference
            wrapped = c[w][CNT_W-1:0] - prev_count[w][CNT_W-1:0];
            delta = wrapped;
            spd[w] = clamp32(round_half_up(delta * longint'($signed(wheel_scale[w])),
                                           WHEEL_SHIFT));
            prev_count[w] = c[w];
            r[w] = 32'(spd[w]);
        end
        sx = spd[0] + spd[1] + spd[2] + spd[3];
        sy = -spd[0] + spd[1] + spd[2] - spd[3];
        sw = -spd[0] + spd[1] - spd[2] + spd[3];
        recip = yaw_recip;
        r[4] = 32'(clamp32(round_half_up(sx, QUART_SHIFT)));
        r[5] = 32'(clamp32(round_half_up(sy, QUART_SHIFT)));
        r[6] = 32'(clamp32(round_half_up(sw * recip, YAW_SHIFT)));
        return r;
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        logic [SCALE_W-1:0] mag;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom;
            default:
            begin
                mag = $urandom_range(1, 1 << 22);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    // upper byte is random noise outside the 24 bit register
    function automatic logic [SCALE_W-1:0] pick_recip();
        logic [INV_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 24'd1;
            2: v = '1;
            3: v = INV_W'($urandom);
            default: v = INV_W'($urandom_range(1 << 16, 1 << 20));
        endcase
        return {8'($urandom), v};
    endfunction

    // mostly plausible encoder motion, some jumps across the wrap point
    function automatic wheel_counts_t next_counts(input int reach);
        wheel_counts_t c;
        int            mode;
        mode = $urandom_range(0, 99);
        for (int w = 0; w < WHEELS; w++)
        begin
            if (mode < 70)
                c[w] = prev_count[w] + 16'($urandom_range(0, 2 * reach) - reach);
            else if (mode < 85)
                c[w] = 16'($urandom);
            else if (mode < 95)
                c[w] = prev_count[w] + 16'h7FFF + 16'($urandom_range(0, 2));
            else
                c[w] = prev_count[w];
        end
        return c;
    endfunction

    task automatic settle();
        while (pending_odometry.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high; caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx < WHEELS)
            wheel_scale[idx[$clog2(WHEELS)-1:0]] = value;
        else if (idx == REG_INV_SPAN)
            yaw_recip = value[INV_W-1:0];
    endtask

    task automatic shuffle_config();
        for (int w = 0; w < WHEELS; w++)
            if ($urandom_range(0, 9) < 8)
                write_reg(REG_SCALE_LF + CFG_IDX_W'(w), pick_scale());
        if ($urandom_range(0, 9) < 8)
            write_reg(REG_INV_SPAN, pick_recip());
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), $urandom);
        cfg_we <= 1'b0;
    endtask

    // tvalid stays high across back-to-back words unless a random gap is drawn outside the calm phase
    task automatic send_word(input wheel_counts_t c, input logic typed, input odo_word_t known);
        odo_word_t predicted;
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_odometry(c);
        pending_odometry.push_back(typed ? known : predicted);
    endtask

    // result side: check, then roll the next tready
    initial
    begin : sink
        odo_word_t got, want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_odometry.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected word %h", got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_odometry.pop_front();
                    for (int k = 0; k < ODO_FIELDS; k++)
                        if (got[k] !== want[k])
                        begin
                            if (mismatch_count < 10)
                                $display("%s mismatch: expected %h, got %h",
                                         field_name[k], want[k], got[k]);
                            mismatch_count++;
                        end
                end
            end
            m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 9);
        end
    end

    initial
    begin : watchdog
        while (cycles_run < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("tb_mecanum_encoder_odometry failed");
        $finish;
    end

    initial
    begin : stimulus
        int reach;
        for (int w = 0; w < WHEELS; w++)
        begin
            prev_count[w]  = '0;
            wheel_scale[w] = SCALE_RESET;
        end
        yaw_recip = INV_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_CFG)
            begin
                s_tvalid <= 1'b0;
                settle();
                write_reg(PLAN[r].idx, PLAN[r].wdata);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_word(PLAN[r].counts, PLAN[r].typed, PLAN[r].result);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            s_tvalid <= 1'b0;
            settle();
            shuffle_config();
            calm  = (phase == CALM_PHASE);
            reach = reach_table[$urandom_range(0, 4)];
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(next_counts(reach), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_mecanum_encoder_odometry passed");
        else
            $display("tb_mecanum_encoder_odometry failed");
        $finish;
    end

endmodule

### mecanum_encoder_odometry.f
hdl/mceo_pkg.sv
hdl/mecanum_encoder_odometry.sv
bench/tb_mecanum_encoder_odometry.sv
